/* rtl/tfp_pkg.sv */
// tactile frame parser package: result type, config type, codes and constants
`default_nettype none
package tfp_pkg;

  localparam logic [7:0] HDR_BYTES = 8'd7;
  localparam logic [7:0] MIN_FRAME_LEN = HDR_BYTES + 8'd1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_END   = 2'd1;
  localparam logic [1:0] ST_BAD_SENS  = 2'd2;
  localparam logic [1:0] ST_TOO_SHORT = 2'd3;

  localparam logic KIND_TAXEL = 1'b0;
  localparam logic KIND_EOF   = 1'b1;

  localparam logic [7:0] CFG_START       = 8'd0;
  localparam logic [7:0] CFG_END         = 8'd1;
  localparam logic [7:0] CFG_SENSOR_LOW  = 8'd2;
  localparam logic [7:0] CFG_SENSOR_HIGH = 8'd3;

  typedef struct packed {
    logic [7:0] start_value;
    logic [7:0] end_value;
    logic [7:0] sensor_low;
    logic [7:0] sensor_high;
  } tfp_cfg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] taxel_value;
    logic [6:0]  taxel_index;
    logic [7:0]  sensor_id;
    logic [31:0] stamp;
    logic [1:0]  status;
    logic        last;
  } tfp_res_t;

endpackage
`default_nettype wire

/* rtl/tfp_cfg.sv */
// tactile frame parser configuration registers
`default_nettype none
module tfp_cfg
  import tfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_en,
  input  wire logic [7:0] wr_index,
  input  wire logic [7:0] wr_data,
  output tfp_cfg_t        cfg
);

  tfp_cfg_t cfg_r;
  tfp_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_START:       cfg_nxt.start_value = wr_data;
        CFG_END:         cfg_nxt.end_value   = wr_data;
        CFG_SENSOR_LOW:  cfg_nxt.sensor_low  = wr_data;
        CFG_SENSOR_HIGH: cfg_nxt.sensor_high = wr_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_value <= 8'd1;
      cfg_r.end_value   <= 8'd10;
      cfg_r.sensor_low  <= 8'd0;
      cfg_r.sensor_high <= 8'd255;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* rtl/tfp_core.sv */
// tactile frame parser state machine: header, payload pairing and frame check
`default_nettype none
module tfp_core
  import tfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       beat,
  input  wire logic [7:0] rx_byte,
  input  wire tfp_cfg_t   cfg,
  output logic            res_valid,
  output tfp_res_t        res
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0]  phase_r,     phase_nxt;
  logic [7:0]  position_r,  position_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [7:0]  sensor_r,    sensor_nxt;
  logic [31:0] stamp_r,     stamp_nxt;
  logic [7:0]  low_r,       low_nxt;
  logic [6:0]  words_r,     words_nxt;

  logic [7:0]  pos_inc;
  logic        frame_end;
  logic        sens_bad;

  assign pos_inc   = position_r + 8'd1;
  assign frame_end = ({1'b0, position_r} + 9'd1) >= {1'b0, frame_len_r};
  assign sens_bad  = (sensor_r < cfg.sensor_low) || (sensor_r > cfg.sensor_high);

  always_comb begin
    phase_nxt     = phase_r;
    position_nxt  = position_r;
    frame_len_nxt = frame_len_r;
    sensor_nxt    = sensor_r;
    stamp_nxt     = stamp_r;
    low_nxt       = low_r;
    words_nxt     = words_r;
    res_valid     = 1'b0;
    res           = '0;
    if (beat) begin
      unique case (phase_r)
        PH_HEAD: begin
          position_nxt = pos_inc;
          if (pos_inc >= HDR_BYTES) begin
            phase_nxt = PH_DATA;
          end
          if (position_r == 8'd1) begin
            frame_len_nxt = rx_byte;
            if (rx_byte < MIN_FRAME_LEN) begin
              res_valid    = 1'b1;
              res.kind     = KIND_EOF;
              res.status   = ST_TOO_SHORT;
              res.last     = 1'b1;
              phase_nxt    = PH_HUNT;
              position_nxt = 8'd0;
            end
          end else if (position_r == 8'd2) begin
            sensor_nxt = rx_byte;
          end else begin
            stamp_nxt = {stamp_r[23:0], rx_byte};
          end
        end
        PH_DATA: begin
          res.sensor_id   = sensor_r;
          res.stamp       = stamp_r;
          res.taxel_index = words_r;
          if (frame_end) begin
            res_valid    = 1'b1;
            res.kind     = KIND_EOF;
            res.last     = 1'b1;
            // terminator first, then sensor range
            if (rx_byte != cfg.end_value) begin
              res.status = ST_BAD_END;
            end else if (sens_bad) begin
              res.status = ST_BAD_SENS;
            end else begin
              res.status = ST_OK;
            end
            phase_nxt    = PH_HUNT;
            position_nxt = 8'd0;
          end else if (position_r[0]) begin
            // low byte of a taxel word
            low_nxt      = rx_byte;
            position_nxt = pos_inc;
          end else begin
            res_valid       = 1'b1;
            res.kind        = KIND_TAXEL;
            res.taxel_value = {rx_byte, low_r};
            words_nxt       = words_r + 7'd1;
            position_nxt    = pos_inc;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (rx_byte == cfg.start_value) begin
            phase_nxt     = PH_HEAD;
            position_nxt  = 8'd1;
            frame_len_nxt = 8'd0;
            sensor_nxt    = 8'd0;
            stamp_nxt     = 32'd0;
            low_nxt       = 8'd0;
            words_nxt     = 7'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      position_r  <= 8'd0;
      frame_len_r <= 8'd0;
      sensor_r    <= 8'd0;
      stamp_r     <= 32'd0;
      low_r       <= 8'd0;
      words_r     <= 7'd0;
    end else begin
      phase_r     <= phase_nxt;
      position_r  <= position_nxt;
      frame_len_r <= frame_len_nxt;
      sensor_r    <= sensor_nxt;
      stamp_r     <= stamp_nxt;
      low_r       <= low_nxt;
      words_r     <= words_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/tfp_obuf.sv */
// tactile frame parser result register with skid stage
`default_nettype none
module tfp_obuf
  import tfp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire tfp_res_t push_res,
  input  wire logic     out_stall,
  output logic          out_valid,
  output tfp_res_t      out_res,
  output logic          full
);

  logic     out_v_r,  out_v_nxt;
  logic     skid_v_r, skid_v_nxt;
  tfp_res_t out_r,    out_nxt;
  tfp_res_t skid_r,   skid_nxt;
  logic     take;

  assign take = out_v_r && !out_stall;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (take) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || take) begin
        out_nxt   = push_res;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_res;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign full      = skid_v_r;

endmodule
`default_nettype wire

/* rtl/tactile_frame_parser.sv */
// tactile frame parser top level
// a result reaches out_* from the result register, or via the skid stage on a stall
// throughput: one byte per cycle while in_stall is low; the parse state updates on each accepted byte
// input stalls only while the skid stage behind the result register is full
// reset (rst_n low, synchronous): hunting for start, config back to defaults,
// result and skid stages empty
`default_nettype none
module tactile_frame_parser
  import tfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [15:0]      out_taxel_value,
  output logic [6:0]       out_taxel_index,
  output logic [7:0]       out_sensor_id,
  output logic [31:0]      out_stamp,
  output logic [1:0]       out_status,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  tfp_cfg_t cfg;
  tfp_res_t core_res;
  tfp_res_t out_res;
  logic     core_valid;
  logic     obuf_full;
  logic     beat;

  assign cfg_ready = 1'b1;
  assign in_stall  = obuf_full;
  assign beat      = in_valid && !obuf_full;

  tfp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .rx_byte   (in_rx_byte),
    .cfg       (cfg),
    .res_valid (core_valid),
    .res       (core_res)
  );

  tfp_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (core_valid),
    .push_res  (core_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (obuf_full)
  );

  assign out_kind        = out_res.kind;
  assign out_taxel_value = out_res.taxel_value;
  assign out_taxel_index = out_res.taxel_index;
  assign out_sensor_id   = out_res.sensor_id;
  assign out_stamp       = out_res.stamp;
  assign out_status      = out_res.status;
  assign out_last        = out_res.last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    obuf_full |-> out_valid)
    else $error("skid stage holds a beat while result register is empty");

  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == out_last))
    else $error("kind and last disagree");

  a_status_on_eof: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_kind == KIND_EOF))
    else $error("error status on a taxel word");

  a_short_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_TOO_SHORT)) |->
      ((out_stamp == 32'd0) && (out_sensor_id == 8'd0) && (out_taxel_index == 7'd0)))
    else $error("too-short result carries header data");

  a_full_blocks_push: assert property (@(posedge clk) disable iff (!rst_n)
    obuf_full |-> !core_valid)
    else $error("result produced while skid stage is full");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// testbench for tactile_frame_parser: directed table and random framed bytes
module tb_top
  import tfp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 100000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_BYTES = 125;

  typedef enum logic [1:0] {HUNT, HEADER, PAYLOAD} parse_phase_e;

  typedef struct {
    logic [7:0] rx;
    bit         pinned;
    tfp_res_t   res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [15:0] out_taxel_value;
  logic [6:0]  out_taxel_index;
  logic [7:0]  out_sensor_id;
  logic [31:0] out_stamp;
  logic [1:0]  out_status;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'd0;
  logic [7:0]  cfg_data = 8'd0;

  tactile_frame_parser dut (.*);

  // predictor state
  tfp_cfg_t     cfg_shadow;
  parse_phase_e ph;
  logic [7:0]   pos, flen, sensor_q, low_q;
  logic [31:0]  stamp_q;
  logic [6:0]   word_idx;

  tfp_res_t due_q[$];
  dir_row_t pin_q[$];
  tfp_cfg_t cfg_now;
  int       errors = 0;
  int       cycles = 0;
  int       frame_bytes = 0;
  int       in_idle_pct = 21;
  int       out_idle_pct = 80;
  bit       squeeze_req = 1'b0;
  bit       squeeze_done = 1'b0;
  int       hold_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tactile_frame_parser: mismatch");
      $finish;
    end
  end

  function automatic tfp_res_t eof_res(logic [6:0] idx, logic [7:0] sid, logic [31:0] st,
                                       logic [1:0] code);
    return {KIND_EOF, 16'd0, idx, sid, st, code, 1'b1};
  endfunction

  function automatic dir_row_t row(logic [7:0] rx, bit pinned = 1'b0, tfp_res_t res = '0);
    dir_row_t d;
    d.rx = rx;
    d.pinned = pinned;
    d.res = res;
    return d;
  endfunction

  function automatic string res_str(tfp_res_t r);
    return $sformatf("kind=%0d value=%h index=%0d sensor=%h stamp=%h status=%0d last=%0d",
                     r.kind, r.taxel_value, r.taxel_index, r.sensor_id, r.stamp, r.status,
                     r.last);
  endfunction

  task automatic parse_byte(input logic [7:0] b, output bit fired, output tfp_res_t r);
    logic [7:0] rel;
    logic [1:0] code;
    fired = 1'b0;
    r = '0;
    rel = pos - HDR_BYTES;
    case (ph)
      HEADER: begin
        if (pos == 8'd1 && b < MIN_FRAME_LEN) begin
          flen = b;
          fired = 1'b1;
          r = eof_res(7'd0, 8'd0, 32'd0, ST_TOO_SHORT);
          ph = HUNT;
          pos = 8'd0;
        end else begin
          if (pos == 8'd1) flen = b;
          else if (pos == 8'd2) sensor_q = b;
          else stamp_q = {stamp_q[23:0], b};
          pos = pos + 8'd1;
          if (pos >= HDR_BYTES) ph = PAYLOAD;
        end
      end
      PAYLOAD: begin
        if ({1'b0, pos} + 9'd1 >= {1'b0, flen}) begin
          if (b != cfg_shadow.end_value) code = ST_BAD_END;
          else if (sensor_q < cfg_shadow.sensor_low || sensor_q > cfg_shadow.sensor_high)
            code = ST_BAD_SENS;
          else code = ST_OK;
          fired = 1'b1;
          r = eof_res(word_idx, sensor_q, stamp_q, code);
          ph = HUNT;
          pos = 8'd0;
        end else if (!rel[0]) begin
          low_q = b;
          pos = pos + 8'd1;
        end else begin
          fired = 1'b1;
          r = {KIND_TAXEL, b, low_q, word_idx, sensor_q, stamp_q, ST_OK, 1'b0};
          word_idx = word_idx + 7'd1;
          pos = pos + 8'd1;
        end
      end
      default: begin
        ph = HUNT;
        if (b == cfg_shadow.start_value) begin
          ph = HEADER;
          pos = 8'd1;
          flen = 8'd0;
          sensor_q = 8'd0;
          stamp_q = 32'd0;
          low_q = 8'd0;
          word_idx = 7'd0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    tfp_res_t got, want, pr;
    bit fired;
    dir_row_t pin;
    if (!rst_n) begin
      cfg_shadow = {8'd1, 8'd10, 8'd0, 8'd255};
      ph = HUNT;
      pos = 8'd0;
      flen = 8'd0;
      sensor_q = 8'd0;
      stamp_q = 32'd0;
      low_q = 8'd0;
      word_idx = 7'd0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_kind, out_taxel_value, out_taxel_index, out_sensor_id, out_stamp,
               out_status, out_last};
        if (due_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result at cycle %0d: %s", cycles, res_str(got));
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch at cycle %0d: expected %s, got %s", cycles,
                       res_str(want), res_str(got));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START:       cfg_shadow.start_value = cfg_data;
          CFG_END:         cfg_shadow.end_value = cfg_data;
          CFG_SENSOR_LOW:  cfg_shadow.sensor_low = cfg_data;
          CFG_SENSOR_HIGH: cfg_shadow.sensor_high = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        parse_byte(in_rx_byte, fired, pr);
        if (pin_q.size() > 0) begin
          pin = pin_q.pop_front();
          if (pin.pinned) begin
            fired = 1'b1;
            pr = pin.res;
          end
        end
        if (fired) due_q.insert(due_q.size(), pr);
      end
    end
  end

  // receiver side: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (squeeze_req && !squeeze_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      squeeze_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(0, 99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame();
    int r, len, full, total;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 8) len = $urandom_range(0, 7);
    else if (r < 11) len = 255;
    else len = $urandom_range(8, 40);
    full = (len < MIN_FRAME_LEN) ? 2 : len;
    total = ($urandom_range(0, 99) < 8) ? $urandom_range(1, full - 1) : full;
    for (int i = 0; i < total; i++) begin
      if (i == 0) b = cfg_now.start_value;
      else if (i == 1) b = len[7:0];
      else if (i == full - 1)
        b = ($urandom_range(0, 99) < 80) ? cfg_now.end_value : 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(0, 255));
      send_byte(b);
      frame_bytes++;
    end
    if ($urandom_range(0, 99) < 20)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic put_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_cfg(input tfp_cfg_t c);
    put_reg(CFG_START, c.start_value);
    put_reg(CFG_END, c.end_value);
    put_reg(CFG_SENSOR_LOW, c.sensor_low);
    put_reg(CFG_SENSOR_HIGH, c.sensor_high);
    cfg_valid <= 1'b0;
    cfg_now = c;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    dir_row_t rows[$];
    tfp_cfg_t plan[6];
    cfg_now = {8'd1, 8'd10, 8'd0, 8'd255};
    // noise, zero and boundary lengths, odd payload, good and bad terminator
    rows = {
      row(8'h00),
      row(8'hFF),
      row(8'h01),
      row(8'h00, 1'b1, eof_res(7'd0, 8'd0, 32'd0, ST_TOO_SHORT)),
      row(8'h01),
      row(8'h07, 1'b1, eof_res(7'd0, 8'd0, 32'd0, ST_TOO_SHORT)),
      row(8'h01),
      row(8'h0B),
      row(8'hFF),
      row(8'hFF),
      row(8'h00),
      row(8'h00),
      row(8'h01),
      row(8'h34),
      row(8'h12),
      row(8'h99),
      row(8'h0A, 1'b1, eof_res(7'd1, 8'hFF, 32'hFF00_0001, ST_OK)),
      row(8'h01),
      row(8'h08),
      row(8'h00),
      row(8'h00),
      row(8'h00),
      row(8'h00),
      row(8'h00),
      row(8'h0B, 1'b1, eof_res(7'd0, 8'd0, 32'd0, ST_BAD_END))
    };

    plan[0] = {8'd1, 8'd10, 8'd0, 8'd255};
    plan[1] = {8'h00, 8'hFF, 8'hFF, 8'h00};
    plan[2] = {8'hFF, 8'h00, 8'h00, 8'h00};
    plan[3] = {8'h7E, 8'h7F, 8'h40, 8'hBF};
    plan[4] = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 127)), 8'($urandom_range(64, 255))};
    plan[5] = {8'd1, 8'd10, 8'd0, 8'd255};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      pin_q.insert(pin_q.size(), rows[i]);
      send_byte(rows[i].rx);
    end
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        in_idle_pct = 80;
        out_idle_pct = 21;
      end
      if (p == 4) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
        squeeze_req <= 1'b1;
      end
      if (p > 0) write_cfg(plan[p]);
      frame_bytes = 0;
      while (frame_bytes < PHASE_BYTES) send_frame();
      drain();
    end

    errors += due_q.size();
    if (errors == 0) begin
      $display("tactile_frame_parser: match");
    end else begin
      $display("tactile_frame_parser: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tfp_pkg.sv
rtl/tfp_cfg.sv
rtl/tfp_core.sv
rtl/tfp_obuf.sv
rtl/tactile_frame_parser.sv
tb/tb_top.sv
